### src/tswe_pkg.sv
// Shared types and constants for the TFTP stop-and-wait engine.
// Used by tswe_core, tftp_stop_and_wait_engine and the testbench; depends on nothing.
package tswe_pkg;

	localparam int unsigned MAX_PAYLOAD = 512;
	localparam int unsigned HDR_BYTES   = 4;

	localparam logic [15:0] HDR_LEN     = 16'(HDR_BYTES);
	localparam logic [15:0] READ_LIMIT  = 16'(MAX_PAYLOAD + HDR_BYTES);
	localparam logic [23:0] TICK_MAX    = 24'hFF_FFFF;

	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ACK   = 16'd4;
	localparam logic [15:0] OP_ERROR = 16'd5;

	localparam logic [7:0]  RETRIES_RST = 8'd10;
	localparam logic [23:0] TIMEOUT_RST = 24'd1000;

	typedef enum logic [1:0] {
		CFG_WRITE_MODE    = 2'd0,
		CFG_MAX_RETRIES   = 2'd1,
		CFG_TIMEOUT_TICKS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_START  = 2'd0,
		ACT_PACKET = 2'd1,
		ACT_TICK   = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_ACK    = 3'd1,
		CMD_RESEND = 3'd2,
		CMD_ERROR  = 3'd3,
		CMD_ABORT  = 3'd4,
		CMD_DATA   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		WHY_NONE       = 3'd0,
		WHY_AHEAD      = 3'd1,
		WHY_UNEXPECTED = 3'd2,
		WHY_LARGE      = 3'd3,
		WHY_RETRIES    = 3'd4,
		WHY_PEER       = 3'd5
	} why_t;

	typedef logic [9:0] pbytes_t;

	typedef struct packed {
		logic        write_mode;
		logic [7:0]  max_retries;
		logic [23:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		act_t        action;
		logic [15:0] opcode;
		logic [15:0] block_number;
		logic [15:0] packet_length;
	} item_t;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] out_block;
		why_t        error_reason;
		logic        store_payload;
		pbytes_t     payload_bytes;
		logic        session_done;
		logic [7:0]  retries_left;
	} result_t;

endpackage

### src/tswe_core.sv
// Session state registers and the per-word decision logic of the engine.
// Depends on tswe_pkg.
module tswe_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  tswe_pkg::cfg_t    cfg,
	input  tswe_pkg::item_t   item,
	output tswe_pkg::result_t result
);

	logic        active_q;
	logic [15:0] expected_q;
	logic [7:0]  attempts_q;
	logic [23:0] ticks_q;

	logic        active_d;
	logic [15:0] expected_d;
	logic [7:0]  attempts_d;
	logic [23:0] ticks_d;

	logic [15:0] limit;
	logic [23:0] tick_inc;

	always_comb begin
		limit    = cfg.write_mode ? tswe_pkg::HDR_LEN : tswe_pkg::READ_LIMIT;
		tick_inc = (ticks_q != tswe_pkg::TICK_MAX) ? ticks_q + 24'd1 : ticks_q;

		active_d   = active_q;
		expected_d = expected_q;
		attempts_d = attempts_q;
		ticks_d    = ticks_q;

		result               = '0;
		result.command       = tswe_pkg::CMD_NONE;
		result.error_reason  = tswe_pkg::WHY_NONE;

		unique case (item.action)
			tswe_pkg::ACT_START: begin
				active_d   = 1'b1;
				expected_d = cfg.write_mode ? 16'd0 : 16'd1;
				attempts_d = cfg.max_retries;
				ticks_d    = '0;
			end
			tswe_pkg::ACT_PACKET: begin
				if (active_q) begin
					priority if (item.packet_length > limit) begin
						result.command      = tswe_pkg::CMD_ERROR;
						result.error_reason = tswe_pkg::WHY_LARGE;
						active_d            = 1'b0;
					end else if (item.packet_length < tswe_pkg::HDR_LEN) begin
						result.command      = tswe_pkg::CMD_ERROR;
						result.error_reason = tswe_pkg::WHY_UNEXPECTED;
						active_d            = 1'b0;
					end else if (item.opcode == tswe_pkg::OP_ERROR) begin
						// The block field carries the peer's error code here.
						result.command      = tswe_pkg::CMD_ABORT;
						result.error_reason = tswe_pkg::WHY_PEER;
						active_d            = 1'b0;
					end else if (!cfg.write_mode) begin
						priority if (item.opcode == tswe_pkg::OP_DATA &&
								item.block_number == expected_q) begin
							result.command       = tswe_pkg::CMD_ACK;
							result.out_block     = expected_q;
							result.store_payload = 1'b1;
							result.payload_bytes = tswe_pkg::pbytes_t'(
								item.packet_length - tswe_pkg::HDR_LEN);
							expected_d = expected_q + 16'd1;
							attempts_d = cfg.max_retries;
							ticks_d    = '0;
							// A short block is the last one of the file.
							if (item.packet_length < tswe_pkg::READ_LIMIT) begin
								result.session_done = 1'b1;
								active_d            = 1'b0;
							end
						end else if (item.opcode == tswe_pkg::OP_DATA &&
								item.block_number < expected_q) begin
							result.command = tswe_pkg::CMD_RESEND;
						end else if (item.block_number > expected_q) begin
							result.command      = tswe_pkg::CMD_ERROR;
							result.error_reason = tswe_pkg::WHY_AHEAD;
							active_d            = 1'b0;
						end else begin
							result.command      = tswe_pkg::CMD_ERROR;
							result.error_reason = tswe_pkg::WHY_UNEXPECTED;
							active_d            = 1'b0;
						end
					end else begin
						priority if (item.opcode != tswe_pkg::OP_ACK) begin
							result.command      = tswe_pkg::CMD_ERROR;
							result.error_reason = tswe_pkg::WHY_UNEXPECTED;
							active_d            = 1'b0;
						end else if (item.block_number == expected_q) begin
							result.command   = tswe_pkg::CMD_DATA;
							result.out_block = expected_q + 16'd1;
							expected_d       = expected_q + 16'd1;
							attempts_d       = cfg.max_retries;
							ticks_d          = '0;
						end else if (item.block_number > expected_q) begin
							result.command      = tswe_pkg::CMD_ERROR;
							result.error_reason = tswe_pkg::WHY_AHEAD;
							active_d            = 1'b0;
						end else begin
							result.command = tswe_pkg::CMD_NONE;
						end
					end
				end
			end
			tswe_pkg::ACT_TICK: begin
				if (active_q) begin
					ticks_d = tick_inc;
					// The count is at least one here, so a timeout of zero acts like one.
					if (tick_inc >= cfg.timeout_ticks) begin
						if (attempts_q == 8'd0) begin
							result.command      = tswe_pkg::CMD_ABORT;
							result.error_reason = tswe_pkg::WHY_RETRIES;
							active_d            = 1'b0;
						end else begin
							result.command = tswe_pkg::CMD_RESEND;
							attempts_d     = attempts_q - 8'd1;
							ticks_d        = '0;
						end
					end
				end
			end
			default: begin
				result.command = tswe_pkg::CMD_NONE;
			end
		endcase

		result.retries_left = attempts_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			expected_q <= '0;
			attempts_q <= '0;
			ticks_q    <= '0;
		end else if (fire) begin
			active_q   <= active_d;
			expected_q <= expected_d;
			attempts_q <= attempts_d;
			ticks_q    <= ticks_d;
		end
	end

endmodule

### src/tftp_stop_and_wait_engine.sv
// Top level of the TFTP stop-and-wait engine: configuration registers,
// input register, output register and the handshakes. Depends on tswe_pkg, tswe_core.
//
// Usage: each input word is one event of a client session: a session start,
// the header fields of a received packet, or a timer tick. Every accepted word
// yields exactly one result word with the command for the packet layer.
// Both channels use valid/stall; a word moves at a rising edge where valid is
// high and stall is low. Configuration registers (write_mode, max_retries,
// timeout_ticks) are written through cfg_write/cfg_index/cfg_data and must only
// change while no word is in flight.
// Path: an accepted word waits in the input register, and its result is held in the output register.
// Throughput: one word per cycle while no result is held; the decision for a word
// is a single pass of compares and increments against the session state, which is
// updated in the same cycle, so the next word sees it with no bubble.
// Reset: the session is idle, all counters clear, the registers take their
// defaults (read mode, 10 retries, 1000 ticks), and both stages are empty.
// Stall: while out_stall holds a pending result, the input register keeps its
// word and in_stall rises once it is occupied; no word is lost or repeated.
module tftp_stop_and_wait_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] opcode,
	input  logic [15:0] block_number,
	input  logic [15:0] packet_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  command,
	output logic [15:0] out_block,
	output logic [2:0]  error_reason,
	output logic        store_payload,
	output logic [9:0]  payload_bytes,
	output logic        session_done,
	output logic [7:0]  retries_left
);

	tswe_pkg::cfg_t    cfg_q;
	tswe_pkg::item_t   item_s1;
	logic              valid_s1;
	tswe_pkg::result_t res_d;
	tswe_pkg::result_t res_s2;
	logic              valid_s2;

	logic out_free;
	logic adv_s1;
	logic in_fire;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_mode    <= 1'b0;
			cfg_q.max_retries   <= tswe_pkg::RETRIES_RST;
			cfg_q.timeout_ticks <= tswe_pkg::TIMEOUT_RST;
		end else if (cfg_write) begin
			unique case (tswe_pkg::cfg_idx_t'(cfg_index))
				tswe_pkg::CFG_WRITE_MODE:    cfg_q.write_mode    <= cfg_data[0];
				tswe_pkg::CFG_MAX_RETRIES:   cfg_q.max_retries   <= cfg_data[7:0];
				tswe_pkg::CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The output register frees up when empty or when its word is taken.
	assign out_free = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire || adv_s1) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.action        <= tswe_pkg::act_t'(action);
			item_s1.opcode        <= opcode;
			item_s1.block_number  <= block_number;
			item_s1.packet_length <= packet_length;
		end
	end

	// The session state advances exactly when the word leaves the input register.
	tswe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.cfg    (cfg_q),
		.item   (item_s1),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign command       = res_s2.command;
	assign out_block     = res_s2.out_block;
	assign error_reason  = res_s2.error_reason;
	assign store_payload = res_s2.store_payload;
	assign payload_bytes = res_s2.payload_bytes;
	assign session_done  = res_s2.session_done;
	assign retries_left  = res_s2.retries_left;

	// A finished transfer is always reported with the ACK of its last block.
	a_done_with_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && session_done) |-> (command == tswe_pkg::CMD_ACK && store_payload))
		else $error("session_done without an ACK that stores");

	// Error and abort commands always carry a reason, other commands never do.
	a_reason_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((error_reason != tswe_pkg::WHY_NONE) ==
			(command == tswe_pkg::CMD_ERROR || command == tswe_pkg::CMD_ABORT)))
		else $error("error_reason does not match command");

	// Stored payload never exceeds one full block.
	a_payload_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && store_payload) |-> (payload_bytes <= 10'(tswe_pkg::MAX_PAYLOAD)))
		else $error("payload_bytes above the block size");

	// The input side stalls only while the output register is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a held output word");

endmodule

### tb/tftp_stop_and_wait_engine_checker.sv
`timescale 1ns / 1ps
// Checker for the TFTP stop-and-wait engine: watches both channels and the register port.
// It predicts every command word and compares it. Depends on tswe_pkg.
module tftp_stop_and_wait_engine_checker
	import tswe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] opcode,
	input  logic [15:0] block_number,
	input  logic [15:0] packet_length,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  command,
	input  logic [15:0] out_block,
	input  logic [2:0]  error_reason,
	input  logic        store_payload,
	input  logic [9:0]  payload_bytes,
	input  logic        session_done,
	input  logic [7:0]  retries_left,
	output int          fault_count,
	output int          outstanding
);

	// Mirror of the register file.
	logic        mode_write;
	logic [7:0]  retry_limit;
	logic [23:0] timeout_limit;

	// Mirror of the session state.
	logic        live;
	logic [15:0] want_block;
	logic [7:0]  tries_left;
	logic [23:0] quiet_ticks;

	result_t     expected_commands[$];
	result_t     seen_word;
	result_t     want_word;

	function automatic void make_progress();
		want_block  = want_block + 16'd1;
		tries_left  = retry_limit;
		quiet_ticks = '0;
	endfunction

	// Works out the command word for one event and advances the session mirror.
	function automatic result_t decide_event(logic [1:0] act, logic [15:0] op,
			logic [15:0] blk, logic [15:0] len);
		result_t     r;
		logic [15:0] lim;
		r = '0;
		r.command = CMD_NONE;
		r.error_reason = WHY_NONE;
		if (act == ACT_START) begin
			live        = 1'b1;
			want_block  = mode_write ? 16'd0 : 16'd1;
			tries_left  = retry_limit;
			quiet_ticks = '0;
		end else if (act == ACT_PACKET && live) begin
			lim = mode_write ? HDR_LEN : READ_LIMIT;
			if (len > lim) begin
				r.command = CMD_ERROR;
				r.error_reason = WHY_LARGE;
				live = 1'b0;
			end else if (len < HDR_LEN) begin
				r.command = CMD_ERROR;
				r.error_reason = WHY_UNEXPECTED;
				live = 1'b0;
			end else if (op == OP_ERROR) begin
				// The block field holds the peer's error code, so it is not looked at.
				r.command = CMD_ABORT;
				r.error_reason = WHY_PEER;
				live = 1'b0;
			end else if (!mode_write) begin
				if (op == OP_DATA && blk == want_block) begin
					r.command = CMD_ACK;
					r.out_block = want_block;
					r.store_payload = 1'b1;
					r.payload_bytes = pbytes_t'(len - HDR_LEN);
					make_progress();
					if (len < READ_LIMIT) begin
						r.session_done = 1'b1;
						live = 1'b0;
					end
				end else if (op == OP_DATA && blk < want_block) begin
					r.command = CMD_RESEND;
				end else if (blk > want_block) begin
					r.command = CMD_ERROR;
					r.error_reason = WHY_AHEAD;
					live = 1'b0;
				end else begin
					r.command = CMD_ERROR;
					r.error_reason = WHY_UNEXPECTED;
					live = 1'b0;
				end
			end else begin
				if (op != OP_ACK) begin
					r.command = CMD_ERROR;
					r.error_reason = WHY_UNEXPECTED;
					live = 1'b0;
				end else if (blk == want_block) begin
					make_progress();
					r.command = CMD_DATA;
					r.out_block = want_block;
				end else if (blk > want_block) begin
					r.command = CMD_ERROR;
					r.error_reason = WHY_AHEAD;
					live = 1'b0;
				end
			end
		end else if (act == ACT_TICK && live) begin
			if (quiet_ticks < TICK_MAX)
				quiet_ticks = quiet_ticks + 24'd1;
			if (quiet_ticks >= timeout_limit) begin
				if (tries_left == 8'd0) begin
					r.command = CMD_ABORT;
					r.error_reason = WHY_RETRIES;
					live = 1'b0;
				end else begin
					r.command = CMD_RESEND;
					tries_left = tries_left - 8'd1;
					quiet_ticks = '0;
				end
			end
		end
		r.retries_left = tries_left;
		return r;
	endfunction

	// Renders every field of one result word for a report line.
	function automatic string word_text(result_t w);
		return $sformatf("cmd=%0d blk=%0d why=%0d store=%0b bytes=%0d done=%0b left=%0d",
			w.command, w.out_block, w.error_reason, w.store_payload,
			w.payload_bytes, w.session_done, w.retries_left);
	endfunction

	task automatic note_fault(string what, result_t want, result_t got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t %s: expected %s, got %s", $time, what,
				word_text(want), word_text(got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_write    = 1'b0;
			retry_limit   = RETRIES_RST;
			timeout_limit = TIMEOUT_RST;
			live          = 1'b0;
			want_block    = '0;
			tries_left    = '0;
			quiet_ticks   = '0;
			expected_commands.delete();
			fault_count   = 0;
			outstanding   = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_word = {command, out_block, error_reason, store_payload,
					payload_bytes, session_done, retries_left};
				if (expected_commands.size() == 0) begin
					note_fault("word with nothing expected", '0, seen_word);
				end else begin
					want_word = expected_commands.pop_front();
					if (seen_word.command !== want_word.command ||
							seen_word.out_block !== want_word.out_block ||
							seen_word.error_reason !== want_word.error_reason ||
							seen_word.store_payload !== want_word.store_payload ||
							seen_word.payload_bytes !== want_word.payload_bytes ||
							seen_word.session_done !== want_word.session_done ||
							seen_word.retries_left !== want_word.retries_left)
						note_fault("mismatch", want_word, seen_word);
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_WRITE_MODE:    mode_write = cfg_data[0];
					CFG_MAX_RETRIES:   retry_limit = cfg_data[7:0];
					CFG_TIMEOUT_TICKS: timeout_limit = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_commands.push_back(decide_event(action, opcode, block_number,
					packet_length));
			outstanding = expected_commands.size();
		end
	end

endmodule

### tb/tftp_stop_and_wait_engine_test.sv
`timescale 1ns / 1ps
// Top of the TFTP stop-and-wait engine testbench: clock, reset, stimulus and verdict.
// Depends on tswe_pkg, tftp_stop_and_wait_engine and tftp_stop_and_wait_engine_checker.
module tftp_stop_and_wait_engine_test;
	import tswe_pkg::*;

	// The engine takes one word per cycle unless its output is held; a generous bound on the whole run
	// covers sender gaps, receiver stalls and the tick runs many times over.
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          PHASE_WORDS = 80;
	// Action code that the engine must ignore, and a register index with no register.
	localparam logic [1:0]  ACT_NOOP    = 2'd3;
	localparam logic [1:0]  CFG_UNUSED  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = CFG_WRITE_MODE;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = ACT_START;
	logic [15:0] opcode = '0;
	logic [15:0] block_number = '0;
	logic [15:0] packet_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  command;
	logic [15:0] out_block;
	logic [2:0]  error_reason;
	logic        store_payload;
	logic [9:0]  payload_bytes;
	logic        session_done;
	logic [7:0]  retries_left;

	int          mismatches;
	int          awaited;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          phase_words = 0;
	int          stall_level = 0;
	int          stall_span = 0;
	logic        writing_file = 1'b0;

	tftp_stop_and_wait_engine DUT (.*);

	tftp_stop_and_wait_engine_checker engine_watch (
		.*,
		.fault_count(mismatches),
		.outstanding(awaited)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The run is cut off if it hangs; a hang always counts as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The receiver stalls in segments: each segment has its own stall density,
	// from never stalling up to stalling with a chance of three in four.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_span  = $urandom_range(8, 64);
			stall_level = $urandom_range(0, 3);
		end
		stall_span--;
		out_stall <= ($urandom_range(0, 3) < stall_level);
	end

	// Offers one word and returns once the engine has taken it. Valid stays up
	// across words of a burst; between bursts it may drop for a random gap.
	task automatic put_word(logic [1:0] act, logic [15:0] op, logic [15:0] blk,
			logic [15:0] len);
		int gap;
		in_valid      <= 1'b1;
		action        <= act;
		opcode        <= op;
		block_number  <= blk;
		packet_length <= len;
		do @(posedge clk); while (in_stall);
		if (act != ACT_NOOP)
			phase_words++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Lets the engine run dry: valid goes low and every predicted word must
	// have come out. The counter is read on the falling edge, clear of the
	// checker's update on the rising one.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (awaited != 0);
		@(posedge clk);
	endtask

	// Writes all three registers back to back. The upper data bits carry junk,
	// which the engine must mask off for the narrow registers.
	task automatic apply_settings(logic wm, logic [7:0] retries, logic [23:0] ticks);
		cfg_write <= 1'b1;
		cfg_index <= CFG_WRITE_MODE;
		cfg_data  <= {23'($urandom), wm};
		@(posedge clk);
		cfg_index <= CFG_MAX_RETRIES;
		cfg_data  <= {16'($urandom), retries};
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT_TICKS;
		cfg_data  <= ticks;
		@(posedge clk);
		cfg_write <= 1'b0;
		writing_file = wm;
	endtask

	// One client session: a start, then mostly in-order traffic with random
	// lengths and content, mixed with ticks, duplicates and the ways a session
	// dies. The cursor is only a guess at the block the engine wants next; a
	// wrong guess merely yields words the engine ignores until the next start.
	task automatic play_session();
		logic [15:0] cursor;
		logic [15:0] lim;
		logic [15:0] len;
		logic [15:0] blk;
		logic [15:0] op;
		logic        alive;
		int          steps;
		int          pick;
		cursor = writing_file ? 16'd0 : 16'd1;
		lim    = writing_file ? HDR_LEN : READ_LIMIT;
		put_word(ACT_START, 16'($urandom), 16'($urandom), 16'($urandom));
		alive = 1'b1;
		steps = $urandom_range(1, 40);
		while (alive && steps > 0) begin
			steps--;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// The block the engine is waiting for. In read mode one in ten
				// is short and finishes the transfer.
				if (writing_file) begin
					put_word(ACT_PACKET, OP_ACK, cursor, HDR_LEN);
				end else begin
					len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(4, 515)) : READ_LIMIT;
					put_word(ACT_PACKET, OP_DATA, cursor, len);
					if (len != READ_LIMIT)
						alive = 1'b0;
				end
				cursor++;
			end else if (pick < 67) begin
				repeat ($urandom_range(1, 6))
					put_word(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
			end else if (pick < 73) begin
				// An old block comes again: a resend in read mode, ignored in write mode.
				if (cursor != 16'd0) begin
					blk = cursor - 16'($urandom_range(1, cursor));
					put_word(ACT_PACKET, writing_file ? OP_ACK : OP_DATA, blk, lim);
				end else begin
					put_word(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
				end
			end else if (pick < 77) begin
				blk = cursor + 16'($urandom_range(1, 16'hFFFF - cursor));
				put_word(ACT_PACKET, writing_file ? OP_ACK : OP_DATA, blk, lim);
				alive = 1'b0;
			end else if (pick < 80) begin
				// Wrong opcode: either the other side's opcode or anything at all.
				op = $urandom_range(0, 1) ? 16'($urandom) : (writing_file ? OP_DATA : OP_ACK);
				blk = $urandom_range(0, 1) ? cursor : 16'($urandom);
				put_word(ACT_PACKET, op, blk, 16'($urandom_range(4, lim)));
				alive = 1'b0;
			end else if (pick < 83) begin
				put_word(ACT_PACKET, OP_ERROR, 16'($urandom), 16'($urandom_range(4, lim)));
				alive = 1'b0;
			end else if (pick < 86) begin
				put_word(ACT_PACKET, 16'($urandom), 16'($urandom),
					16'($urandom_range(65535, lim + 1)));
				alive = 1'b0;
			end else if (pick < 89) begin
				put_word(ACT_PACKET, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 3)));
				alive = 1'b0;
			end else if (pick < 91) begin
				put_word(ACT_NOOP, 16'($urandom), 16'($urandom), 16'($urandom));
			end else if (pick < 93) begin
				// Restart in the middle of a session.
				put_word(ACT_START, 16'($urandom), 16'($urandom), 16'($urandom));
				cursor = writing_file ? 16'd0 : 16'd1;
			end else begin
				put_word(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			end
		end
		// Now and then a packet or tick after the session has ended.
		if ($urandom_range(0, 3) == 0)
			put_word(2'($urandom_range(1, 2)), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic play_until(int target);
		phase_words = 0;
		while (phase_words < target)
			play_session();
	endtask

	task automatic random_phase(logic wm, logic [7:0] retries, logic [23:0] ticks);
		drain();
		apply_settings(wm, retries, ticks);
		play_until(PHASE_WORDS);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write to the index with no register must leave the defaults alone.
		cfg_write <= 1'b1;
		cfg_index <= CFG_UNUSED;
		cfg_data  <= 24'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;

		// Directed read session under the reset defaults: read mode,
		// 10 retries, 1000 ticks.
		put_word(ACT_PACKET, OP_DATA, 16'd1, READ_LIMIT);   // no session yet
		put_word(ACT_TICK, 16'd0, 16'd0, 16'd0);            // tick while idle
		put_word(ACT_NOOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // unknown action
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, OP_DATA, 16'd1, READ_LIMIT);   // full block, stored
		put_word(ACT_PACKET, OP_DATA, 16'd1, READ_LIMIT);   // duplicate, resend
		put_word(ACT_TICK, 16'd0, 16'd0, 16'd0);            // far from timeout
		put_word(ACT_PACKET, OP_DATA, 16'd2, READ_LIMIT);
		put_word(ACT_PACKET, OP_DATA, 16'd3, HDR_LEN);      // empty last block
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, OP_DATA, 16'd1, READ_LIMIT + 16'd1);  // one byte too long
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, OP_DATA, 16'd1, HDR_LEN - 16'd1);     // runt
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, OP_ERROR, 16'hFFFF, HDR_LEN);  // peer error, code in block
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, OP_DATA, 16'hFFFF, READ_LIMIT);       // block ahead
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, 16'hFFFF, 16'd0, HDR_LEN);     // foreign opcode
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, OP_DATA, 16'd1, READ_LIMIT - 16'd1);  // short block ends it
		play_until(PHASE_WORDS);

		// Write mode with no retries and the shortest timeout.
		drain();
		apply_settings(1'b1, 8'd0, 24'd1);
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, OP_ACK, 16'd0, HDR_LEN);       // next data block
		put_word(ACT_PACKET, OP_ACK, 16'd0, HDR_LEN);       // stale ack, ignored
		put_word(ACT_PACKET, OP_ACK, 16'd9, HDR_LEN);       // ack ahead
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_TICK, 16'd0, 16'd0, 16'd0);            // retries exhausted at once
		put_word(ACT_START, 16'd0, 16'd0, 16'd0);
		put_word(ACT_PACKET, OP_ACK, 16'd0, HDR_LEN + 16'd1);      // too long for an ack
		play_until(PHASE_WORDS);

		random_phase(1'b0, 8'd3, 24'd2);
		// A zero timeout behaves like one tick.
		random_phase(1'b0, 8'd255, 24'd0);
		random_phase(1'b1, 8'd2, 24'd5);
		// The longest timeout never expires within this run.
		random_phase(1'b0, 8'd1, 24'hFF_FFFF);
		random_phase(1'b1, 8'd255, 24'd3);
		random_phase(1'($urandom), 8'($urandom_range(0, 8)), 24'($urandom_range(1, 8)));

		drain();
		// A last wait lets any stray words come out to the checker before the verdict.
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
